/* design/fq15_pkg.sv */
// Shared types and constants for the Q15 FIR filter.
`timescale 1ns / 1ps

package fq15_pkg;

    // Sample and coefficient width
    localparam int DATA_W = 16;

    // Clip limits of the accumulated sum
    localparam logic signed [31:0] CLIP_HIGH = 32'sh3FFF_FFFF;
    localparam logic signed [31:0] CLIP_LOW  = 32'shC000_0000;

    // Clip status codes
    localparam logic [1:0] CLIP_NONE = 2'd0;
    localparam logic [1:0] CLIP_POS  = 2'd1;
    localparam logic [1:0] CLIP_NEG  = 2'd2;

    // Input mode codes
    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    // Control that travels with each tap read into the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

endpackage

/* design/fir_filter_q15_saturating.sv */
// Top level of the saturating Q15 FIR filter with loadable coefficients.
//
// Channel  Direction  Handshake              Contents
// s_       in         s_tvalid / s_tready    tuser: mode; tdata: sample, coef_index, coef_value
// m_       out        m_tvalid / m_tready    tdata: filtered, clip_status
// cfg_     in         cfg_valid / cfg_ready  data: mute_warmup
//
// A sample request makes one delay-line and coefficient memory read per tap through a
// single shared multiply-accumulate, followed by the MAC pipeline.
// A coefficient write gives no result.
// After reset a clearing pass zeroes both memories; s_tready stays low.
// A finished result waits in the output register; the next request is accepted meanwhile,
// and its result is held in the MAC until the output register frees up.
`timescale 1ns / 1ps

module fir_filter_q15_saturating #(
    parameter int TAPS = 220
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [15:0] sample, [23:16] coef_index, [39:24] coef_value
    input  logic        s_tuser,   // [0] mode
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] filtered, [17:16] clip_status
    // Configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // mute_warmup
);

    localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W = 33 + IDX_W;
    localparam logic [IDX_W-1:0] LAST_TAP = IDX_W'(TAPS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_HOLD
    } state_t;

    state_t                             state_reg;
    logic [IDX_W-1:0]                   tap_cnt_reg;
    logic [IDX_W-1:0]                   head_reg;
    logic [IDX_W-1:0]                   dly_ptr_reg;
    logic [IDX_W-1:0]                   warm_reg;
    logic                               mute_reg;
    logic                               muted_reg;
    fq15_pkg::mac_ctrl_t                rd_ctrl_reg;
    logic                               m_tvalid_reg;
    logic [23:0]                        m_tdata_reg;

    logic signed [fq15_pkg::DATA_W-1:0] coef_mem [TAPS];
    logic signed [fq15_pkg::DATA_W-1:0] dly_mem  [TAPS];
    logic signed [fq15_pkg::DATA_W-1:0] coef_q_reg;
    logic signed [fq15_pkg::DATA_W-1:0] dly_q_reg;

    logic                               in_mode;
    logic signed [fq15_pkg::DATA_W-1:0] in_sample;
    logic signed [fq15_pkg::DATA_W-1:0] in_coef;
    logic [31:0]                        idx_wide;
    logic                               idx_ok;
    logic                               s_accept;
    logic                               out_free;
    logic                               out_load;
    logic                               clearing;

    logic                               coef_we;
    logic [IDX_W-1:0]                   coef_wa;
    logic signed [fq15_pkg::DATA_W-1:0] coef_wd;
    logic                               dly_we;
    logic [IDX_W-1:0]                   dly_wa;
    logic signed [fq15_pkg::DATA_W-1:0] dly_wd;

    logic                               mac_done;
    logic signed [fq15_pkg::DATA_W-1:0] mac_filtered;
    logic [1:0]                         mac_status;

    // Unpack the request
    assign in_mode   = s_tuser;
    assign in_sample = s_tdata[15:0];
    assign in_coef   = s_tdata[39:24];
    assign idx_wide  = 32'(s_tdata[23:16]);
    assign idx_ok    = idx_wide < 32'(TAPS);

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = out_free && ((state_reg == S_WAIT && mac_done) || state_reg == S_HOLD);
    assign clearing  = (state_reg == S_CLEAR);
    assign cfg_ready = 1'b1;

    // Select memory write ports: clearing pass or request
    always_comb begin
        coef_we = clearing || (s_accept && in_mode == fq15_pkg::MODE_COEF && idx_ok);
        coef_wa = clearing ? tap_cnt_reg : idx_wide[IDX_W-1:0];
        coef_wd = clearing ? '0 : in_coef;
        dly_we  = clearing || (s_accept && in_mode == fq15_pkg::MODE_FILTER);
        dly_wa  = clearing ? tap_cnt_reg : head_reg;
        dly_wd  = clearing ? '0 : in_sample;
    end

    // Coefficient and delay-line memories, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_wa] <= coef_wd;
        end
        if (dly_we) begin
            dly_mem[dly_wa] <= dly_wd;
        end
        coef_q_reg <= coef_mem[tap_cnt_reg];
        dly_q_reg  <= dly_mem[dly_ptr_reg];
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mute_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            mute_reg <= cfg_data;
        end
    end

    // Sequencer: clearing pass, tap sweep and result handoff
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            tap_cnt_reg  <= '0;
            head_reg     <= '0;
            dly_ptr_reg  <= '0;
            warm_reg     <= '0;
            muted_reg    <= 1'b0;
            rd_ctrl_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Tag each tap read for the MAC
            rd_ctrl_reg.valid <= (state_reg == S_RUN);
            rd_ctrl_reg.first <= (state_reg == S_RUN) && (tap_cnt_reg == '0);
            rd_ctrl_reg.last  <= (state_reg == S_RUN) && (tap_cnt_reg == LAST_TAP);
            // Raise valid on a new result, drop it once the result is taken
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    if (tap_cnt_reg == LAST_TAP) begin
                        tap_cnt_reg <= '0;
                        state_reg   <= S_IDLE;
                    end else begin
                        tap_cnt_reg <= tap_cnt_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_accept && in_mode == fq15_pkg::MODE_FILTER) begin
                        dly_ptr_reg <= head_reg;
                        head_reg    <= (head_reg == LAST_TAP) ? '0 : head_reg + 1'b1;
                        tap_cnt_reg <= '0;
                        muted_reg   <= mute_reg && (warm_reg < LAST_TAP);
                        if (warm_reg < LAST_TAP) begin
                            warm_reg <= warm_reg + 1'b1;
                        end
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    dly_ptr_reg <= (dly_ptr_reg == '0) ? LAST_TAP : dly_ptr_reg - 1'b1;
                    if (tap_cnt_reg == LAST_TAP) begin
                        tap_cnt_reg <= '0;
                        state_reg   <= S_WAIT;
                    end else begin
                        tap_cnt_reg <= tap_cnt_reg + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (mac_done) begin
                        if (out_free) begin
                            m_tdata_reg <= {6'b0, mac_status,
                                            muted_reg ? 16'h0000 : mac_filtered};
                            state_reg   <= S_IDLE;
                        end else begin
                            state_reg <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        m_tdata_reg <= {6'b0, mac_status,
                                        muted_reg ? 16'h0000 : mac_filtered};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    fq15_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (rd_ctrl_reg),
        .coef     (coef_q_reg),
        .smp      (dly_q_reg),
        .done     (mac_done),
        .filtered (mac_filtered),
        .status   (mac_status)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // No request is taken while the memories are being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("request accepted during clearing pass");

    // The MAC finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == S_WAIT))
        else $error("MAC result outside wait state");

    // A held result is never overwritten while the output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HOLD && m_tvalid_reg && !m_tready) |=> (state_reg == S_HOLD))
        else $error("held result dropped");

    // Warm-up count saturates at TAPS-1
    assert property (@(posedge aclk) disable iff (!aresetn)
        (warm_reg == LAST_TAP) |=> (warm_reg == LAST_TAP))
        else $error("warm-up count left saturation");

endmodule

/* design/fq15_mac.sv */
// Multiply-accumulate, clip and output scaling for the Q15 FIR filter.
`timescale 1ns / 1ps

module fq15_mac #(
    parameter int ACC_W = 41
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  fq15_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [fq15_pkg::DATA_W-1:0]    coef,
    input  logic signed [fq15_pkg::DATA_W-1:0]    smp,
    output logic                                  done,
    output logic signed [fq15_pkg::DATA_W-1:0]    filtered,
    output logic [1:0]                            status
);

    logic signed [2*fq15_pkg::DATA_W-1:0] prod_reg;
    fq15_pkg::mac_ctrl_t                  ctrl1_reg;
    logic signed [ACC_W-1:0]              acc_reg;
    logic                                 fin_reg;
    logic                                 done_reg;
    logic signed [fq15_pkg::DATA_W-1:0]   filt_reg;
    logic [1:0]                           status_reg;

    logic                                 clip_hi;
    logic                                 clip_lo;
    logic signed [30:0]                   clipped;
    logic [1:0]                           status_next;

    // Stage 1: multiply one tap
    always_ff @(posedge aclk) begin
        prod_reg <= coef * smp;
        if (!aresetn) begin
            ctrl1_reg <= '0;
        end else begin
            ctrl1_reg <= ctrl;
        end
    end

    // Stage 2: accumulate, restart on the first tap
    always_ff @(posedge aclk) begin
        if (ctrl1_reg.valid) begin
            if (ctrl1_reg.first) begin
                acc_reg <= ACC_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
        if (!aresetn) begin
            fin_reg <= 1'b0;
        end else begin
            fin_reg <= ctrl1_reg.valid && ctrl1_reg.last;
        end
    end

    // Clip the sum to the 31-bit range and flag which side
    always_comb begin
        clip_hi = acc_reg > ACC_W'(fq15_pkg::CLIP_HIGH);
        clip_lo = acc_reg < ACC_W'(fq15_pkg::CLIP_LOW);
        if (clip_hi) begin
            clipped     = fq15_pkg::CLIP_HIGH[30:0];
            status_next = fq15_pkg::CLIP_POS;
        end else if (clip_lo) begin
            clipped     = fq15_pkg::CLIP_LOW[30:0];
            status_next = fq15_pkg::CLIP_NEG;
        end else begin
            clipped     = acc_reg[30:0];
            status_next = fq15_pkg::CLIP_NONE;
        end
    end

    // Stage 3: register the scaled result (floor shift by 15)
    always_ff @(posedge aclk) begin
        if (fin_reg) begin
            filt_reg   <= clipped[30:15];
            status_reg <= status_next;
        end
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= fin_reg;
        end
    end

    assign done     = done_reg;
    assign filtered = filt_reg;
    assign status   = status_reg;

endmodule
